FILE: hdl/octa_pkg.sv
`default_nettype none

package octa_pkg;

  // Fixed field widths
  localparam int InW    = 16;  // signed vector component
  localparam int MagW   = 16;  // magnitude, holds 32768
  localparam int AngleW = 10;  // angle result field

  // Angle reported for the zero vector
  localparam logic [AngleW-1:0] ZeroAngle = 10'd512;

  // Value held in the last arctangent entry (equal magnitudes)
  localparam int RomEndValue = 128;

  // Octant info carried along the divider row
  typedef struct packed {
    logic zero;     // both components are zero
    logic x_neg;
    logic y_neg;
    logic x_major;  // |x| > |y|
  } octa_side_t;

endpackage

`default_nettype wire

FILE: hdl/octa_vec_if.sv
`default_nettype none

interface octa_vec_if import octa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [InW-1:0] vec_x;
  logic signed [InW-1:0] vec_y;

  modport source (output valid, output vec_x, output vec_y, input ready);
  modport sink   (input valid, input vec_x, input vec_y, output ready);
endinterface

`default_nettype wire

FILE: hdl/octa_angle_if.sv
`default_nettype none

interface octa_angle_if import octa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AngleW-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

`default_nettype wire

FILE: hdl/octa_div_cell.sv
`default_nettype none

// One restoring-division step: decides quotient bit Shift.
module octa_div_cell import octa_pkg::*; #(
  parameter int RemW  = 27,
  parameter int DivW  = 16,
  parameter int QuoW  = 11,
  parameter int Shift = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [RemW-1:0]  rem_i,
  input  logic [DivW-1:0]  div_i,
  input  logic [QuoW-1:0]  quo_i,
  input  octa_side_t       side_i,
  output logic             valid_o,
  output logic [RemW-1:0]  rem_o,
  output logic [DivW-1:0]  div_o,
  output logic [QuoW-1:0]  quo_o,
  output octa_side_t       side_o
);

  logic [RemW-1:0] dsh;
  logic            ge;
  logic [RemW-1:0] rem_d;
  logic [QuoW-1:0] quo_d;
  logic            valid_q;
  logic [RemW-1:0] rem_q;
  logic [DivW-1:0] div_q;
  logic [QuoW-1:0] quo_q;
  octa_side_t      side_q;

  // Trial subtract of the shifted divisor
  always_comb begin
    dsh   = RemW'(div_i) << Shift;
    ge    = (rem_i >= dsh);
    rem_d = ge ? (rem_i - dsh) : rem_i;
    quo_d = quo_i;
    quo_d[Shift] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      div_q  <= div_i;
      quo_q  <= quo_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

FILE: hdl/octa_atan_rom.sv
`default_nettype none

// Arctangent table, filled at elaboration, registered read.
// Entry i: smallest d with floor(tan(d * 6.28 / ANGLE_STEPS) * TAN_ENTRIES) >= i,
// evaluated in Q60 fixed point; the last entry holds RomEndValue.
module octa_atan_rom import octa_pkg::*; #(
  parameter int ANGLE_STEPS = 1024,
  parameter int TAN_ENTRIES = 1024,
  parameter int IdxW        = 11,
  parameter int ValW        = 9
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [IdxW-1:0] idx_i,
  output logic [ValW-1:0] val_o
);

  localparam int TurnNum     = 628;
  localparam int TurnDen     = 100;
  localparam int FracBits    = 60;
  localparam int SeriesTerms = 20;
  localparam int Cap         = ANGLE_STEPS / 4;

  typedef logic [ValW-1:0] rom_t [TAN_ENTRIES+1];

  // Shift-subtract long division
  function automatic logic [127:0] udiv(input logic [127:0] n, input logic [127:0] dv);
    logic [127:0] q;
    logic [128:0] r;
    q = '0;
    r = '0;
    for (int b = 127; b >= 0; b--) begin
      r = {r[127:0], n[b]};
      if (r >= {1'b0, dv}) begin
        r    = r - {1'b0, dv};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // (a*b) >> 60, low 64 bits
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // floor(tan(d * 6.28 / ANGLE_STEPS) * TAN_ENTRIES) by sine/cosine series
  function automatic logic [63:0] tan_scaled(input logic [63:0] d);
    logic [127:0]       num;
    logic [127:0]       den;
    logic [127:0]       q;
    logic [63:0]        a;
    logic [63:0]        a2;
    logic [63:0]        term;
    logic signed [63:0] s;
    logic signed [63:0] c;
    num = {64'd0, d} * 128'(TurnNum);
    den = 128'(TurnDen) * 128'(ANGLE_STEPS);
    q   = udiv(num << FracBits, den);
    a   = q[63:0];
    a2  = qmul(a, a);
    term = a;
    s    = signed'(a);
    for (int k = 1; k < SeriesTerms; k++) begin
      q    = udiv({64'd0, qmul(term, a2)}, 128'((2 * k) * (2 * k + 1)));
      term = q[63:0];
      if (k[0]) s = s - signed'(term);
      else      s = s + signed'(term);
    end
    term = 64'd1 << FracBits;
    c    = signed'(term);
    for (int k = 1; k < SeriesTerms; k++) begin
      q    = udiv({64'd0, qmul(term, a2)}, 128'((2 * k - 1) * (2 * k)));
      term = q[63:0];
      if (k[0]) c = c - signed'(term);
      else      c = c + signed'(term);
    end
    if (c <= 0 || s < 0) begin
      return '1;
    end
    q = udiv({64'd0, 64'(s)} * 128'(TAN_ENTRIES), {64'd0, 64'(c)});
    return q[63:0];
  endfunction

  // Walk d upward as the index grows
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] d;
    logic [63:0] cur;
    d   = '0;
    cur = tan_scaled(64'd0);
    for (int i = 0; i < TAN_ENTRIES; i++) begin
      while (cur < 64'(i) && d < 64'(Cap)) begin
        d   = d + 64'd1;
        cur = tan_scaled(d);
      end
      rom[i] = ValW'(d);
    end
    rom[TAN_ENTRIES] = ValW'(RomEndValue);
    return rom;
  endfunction

  localparam rom_t Rom = build_rom();

  logic [ValW-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= Rom[idx_i];
    end
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

FILE: hdl/octant_atan2_table.sv
`default_nettype none

// Octant atan2: takes a signed (vec_x, vec_y) beat and returns its direction in
// ANGLE_STEPS steps per turn (0 toward -y, a quarter turn toward +x), reported
// on the 10-bit angle field. The zero vector gives 512. One vector is accepted
// every cycle while the output side keeps up. The pipeline is two front stages
// (magnitude, octant fold and scaling), one cell per quotient bit in the
// divider row, the registered arctangent table read, and the output register.
// The table holds TAN_ENTRIES+1 constant entries computed at elaboration. The
// whole pipeline holds while a finished angle waits at the output.
module octant_atan2_table import octa_pkg::*; #(
  parameter int ANGLE_STEPS = 1024,
  parameter int TAN_ENTRIES = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  octa_vec_if.sink      vec_i,
  octa_angle_if.source  angle_o
);

  localparam int QuoW   = $clog2(TAN_ENTRIES + 1);
  localparam int RemW   = MagW + QuoW;
  localparam int Cap    = ANGLE_STEPS / 4;
  localparam int ValMax = (Cap > RomEndValue) ? Cap : RomEndValue;
  localparam int ValW   = $clog2(ValMax + 1);
  localparam int SumRaw = $clog2(ANGLE_STEPS) + 2;
  localparam int SumW   = (SumRaw > AngleW) ? SumRaw : AngleW;

  localparam logic [SumW-1:0] BaseQ0   = '0;
  localparam logic [SumW-1:0] BaseQ1   = SumW'(ANGLE_STEPS / 4);
  localparam logic [SumW-1:0] BaseQ2   = SumW'(ANGLE_STEPS / 2);
  localparam logic [SumW-1:0] BaseQ3   = SumW'(ANGLE_STEPS * 3 / 4);
  localparam logic [SumW-1:0] BaseFull = SumW'(ANGLE_STEPS);
  localparam logic [SumW-1:0] AngMask  = SumW'(ANGLE_STEPS - 1);
  localparam logic [QuoW-1:0] TanMax   = QuoW'(TAN_ENTRIES);

  logic adv;

  // Global advance: move when the output register is free or being drained
  assign adv         = !angle_o.valid || angle_o.ready;
  assign vec_i.ready = adv;

  // ---------------- Stage A: magnitudes ----------------
  logic [InW:0]    x_ext, y_ext, x_abs, y_abs;
  logic            a_valid_q;
  logic [MagW-1:0] a_ax_q, a_ay_q;
  logic            a_xneg_q, a_yneg_q;

  always_comb begin
    x_ext = {vec_i.vec_x[InW-1], vec_i.vec_x};
    y_ext = {vec_i.vec_y[InW-1], vec_i.vec_y};
    x_abs = vec_i.vec_x[InW-1] ? ((InW+1)'(0) - x_ext) : x_ext;
    y_abs = vec_i.vec_y[InW-1] ? ((InW+1)'(0) - y_ext) : y_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= vec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_ax_q   <= x_abs[MagW-1:0];
      a_ay_q   <= y_abs[MagW-1:0];
      a_xneg_q <= vec_i.vec_x[InW-1];
      a_yneg_q <= vec_i.vec_y[InW-1];
    end
  end

  // ---------------- Stage B: fold and scale ----------------
  logic            x_major;
  logic [MagW-1:0] mag_min, mag_max;
  octa_side_t      b_side_d;
  logic            b_valid_q;
  logic [RemW-1:0] b_rem_q;
  logic [MagW-1:0] b_div_q;
  octa_side_t      b_side_q;

  always_comb begin
    x_major          = (a_ax_q > a_ay_q);
    mag_min          = x_major ? a_ay_q : a_ax_q;
    mag_max          = x_major ? a_ax_q : a_ay_q;
    b_side_d.zero    = (a_ax_q == '0) && (a_ay_q == '0);
    b_side_d.x_neg   = a_xneg_q;
    b_side_d.y_neg   = a_yneg_q;
    b_side_d.x_major = x_major;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_rem_q  <= RemW'(mag_min) * RemW'(TAN_ENTRIES);
      b_div_q  <= mag_max;
      b_side_q <= b_side_d;
    end
  end

  // Divider row, index 0 carries the stage B register
  logic            c_valid [QuoW+1];
  logic [RemW-1:0] c_rem   [QuoW+1];
  logic [MagW-1:0] c_div   [QuoW+1];
  logic [QuoW-1:0] c_quo   [QuoW+1];
  octa_side_t      c_side  [QuoW+1];

  assign c_valid[0] = b_valid_q;
  assign c_rem[0]   = b_rem_q;
  assign c_div[0]   = b_div_q;
  assign c_side[0]  = b_side_q;
  assign c_quo[0]   = '0;

  // One cell per quotient bit, most significant first
  for (genvar g = 0; g < QuoW; g++) begin : g_cell
    octa_div_cell #(
      .RemW  (RemW),
      .DivW  (MagW),
      .QuoW  (QuoW),
      .Shift (QuoW - 1 - g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (c_valid[g]),
      .rem_i   (c_rem[g]),
      .div_i   (c_div[g]),
      .quo_i   (c_quo[g]),
      .side_i  (c_side[g]),
      .valid_o (c_valid[g+1]),
      .rem_o   (c_rem[g+1]),
      .div_o   (c_div[g+1]),
      .quo_o   (c_quo[g+1]),
      .side_o  (c_side[g+1])
    );
  end

  // ---------------- Table read ----------------
  logic [QuoW-1:0] rom_idx;
  logic [ValW-1:0] rom_val;
  logic            r_valid_q;
  octa_side_t      r_side_q;

  always_comb begin
    if (c_side[QuoW].zero) begin
      rom_idx = '0;
    end else if (c_quo[QuoW] > TanMax) begin
      rom_idx = TanMax;
    end else begin
      rom_idx = c_quo[QuoW];
    end
  end

  octa_atan_rom #(
    .ANGLE_STEPS (ANGLE_STEPS),
    .TAN_ENTRIES (TAN_ENTRIES),
    .IdxW        (QuoW),
    .ValW        (ValW)
  ) u_rom (
    .clk_i (clk_i),
    .en_i  (adv),
    .idx_i (rom_idx),
    .val_o (rom_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (adv) begin
      r_valid_q <= c_valid[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_side_q <= c_side[QuoW];
    end
  end

  // ---------------- Octant base and output register ----------------
  logic [SumW-1:0]   base;
  logic              add;
  logic [SumW-1:0]   sum;
  logic [SumW-1:0]   wrapped;
  logic [AngleW-1:0] angle_d;
  logic              out_valid_q;
  logic [AngleW-1:0] angle_q;

  always_comb begin
    if (r_side_q.x_major) begin
      if (r_side_q.x_neg) begin
        base = BaseQ3;
        add  = r_side_q.y_neg;
      end else begin
        base = BaseQ1;
        add  = !r_side_q.y_neg;
      end
    end else if (r_side_q.y_neg) begin
      base = r_side_q.x_neg ? BaseFull : BaseQ0;
      add  = !r_side_q.x_neg;
    end else begin
      base = BaseQ2;
      add  = r_side_q.x_neg;
    end
    sum     = add ? (base + SumW'(rom_val)) : (base - SumW'(rom_val));
    wrapped = sum & AngMask;
    angle_d = r_side_q.zero ? ZeroAngle : wrapped[AngleW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= r_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      angle_q <= angle_d;
    end
  end

  assign angle_o.valid = out_valid_q;
  assign angle_o.angle = angle_q;

`ifndef ASSERT_OFF
  // A stalled result blocks new input beats
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_o.valid && !angle_o.ready |-> !vec_i.ready)
    else $error("input accepted while output stalled");

  // Divider row ends with an in-range quotient and a proper remainder
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid[QuoW] && !c_side[QuoW].zero |-> c_quo[QuoW] <= TanMax)
    else $error("quotient beyond table size");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid[QuoW] && !c_side[QuoW].zero |-> c_rem[QuoW] < RemW'(c_div[QuoW]))
    else $error("divider remainder not below divisor");

  // Zero vector reaches the output as the fixed angle
  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && r_valid_q && r_side_q.zero |=> angle_o.valid && angle_o.angle == ZeroAngle)
    else $error("zero vector angle wrong");
`endif

endmodule

`default_nettype wire
